[rtl/core/ubxanr_pkg.sv]
// ----------------------------------------------------------------------------
// ubxanr_pkg
// Shared types and constants of the UBX acknowledge receiver: transaction
// payloads, the configuration set, input modes, verdict and register codes.
// ----------------------------------------------------------------------------
package ubxanr_pkg;

  // Input modes.
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_ACK     = 2'd1;
  localparam logic [1:0] VERDICT_NAK     = 2'd2;
  localparam logic [1:0] VERDICT_TIMEOUT = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_EXPECT_CLASS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXPECT_ID    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_MS   = 2'd2;

  // Register reset values.
  localparam logic [7:0]  EXPECT_CLASS_RST = 8'd6;
  localparam logic [7:0]  EXPECT_ID_RST    = 8'd8;
  localparam logic [15:0] TIMEOUT_MS_RST   = 16'd1000;

  // UBX framing constants.
  localparam logic [7:0] UBX_SYNC1     = 8'hB5;
  localparam logic [7:0] UBX_SYNC2     = 8'h62;
  localparam logic [7:0] UBX_CLASS_ACK = 8'h05;
  localparam logic [7:0] UBX_ID_ACK    = 8'h01;
  localparam logic [7:0] UBX_ID_NAK    = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] fail_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  expect_class;
    logic [7:0]  expect_id;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

[rtl/core/ubxanr_cfg.sv]
// ----------------------------------------------------------------------------
// ubxanr_cfg
// Configuration registers: expected class, expected id and timeout limit,
// written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ubxanr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ubxanr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ubxanr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ubxanr_pkg::cfg_t                 cfg_o
);

  ubxanr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ubxanr_pkg::CFG_EXPECT_CLASS: cfg_d.expect_class = cfg_wdata_i[7:0];
        ubxanr_pkg::CFG_EXPECT_ID:    cfg_d.expect_id    = cfg_wdata_i[7:0];
        ubxanr_pkg::CFG_TIMEOUT_MS:   cfg_d.timeout_ms   = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expect_class <= ubxanr_pkg::EXPECT_CLASS_RST;
      cfg_q.expect_id    <= ubxanr_pkg::EXPECT_ID_RST;
      cfg_q.timeout_ms   <= ubxanr_pkg::TIMEOUT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/ubxanr_core.sv]
// ----------------------------------------------------------------------------
// ubxanr_core
// Frame parser, Fletcher checksum, millisecond timer and failure counter.
// State advances by one transaction whenever step_i is high.
// ----------------------------------------------------------------------------
module ubxanr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ubxanr_pkg::in_t   item_i,
  input  ubxanr_pkg::cfg_t  cfg_i,
  output ubxanr_pkg::out_t  res_o
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_IDENT   = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  frame_class_q, frame_class_d;
  logic [7:0]  frame_ident_q, frame_ident_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_sum_a_q, rx_sum_a_d;
  logic [15:0] pay_len_q, pay_len_d;
  logic [15:0] pay_idx_q, pay_idx_d;
  logic [7:0]  head0_q, head0_d;
  logic [7:0]  head1_q, head1_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        armed_q, armed_d;
  logic [15:0] fails_q, fails_d;

  logic [7:0]  b;
  logic [7:0]  add_a, add_b;
  logic [15:0] idx_inc;
  logic [15:0] len_full;
  logic [15:0] fails_inc;
  logic [1:0]  verdict;
  logic        frame_ok;

  always_comb begin
    b         = item_i.data_byte;
    add_a     = sum_a_q + b;
    add_b     = sum_b_q + add_a;
    idx_inc   = pay_idx_q + 16'd1;
    len_full  = {b, pay_len_q[7:0]};
    fails_inc = (fails_q == 16'hFFFF) ? fails_q : fails_q + 16'd1;
    frame_ok  = (sum_a_q == rx_sum_a_q) && (sum_b_q == b) && (pay_len_q >= 16'd2) &&
                (head0_q == cfg_i.expect_class) && (head1_q == cfg_i.expect_id) &&
                (frame_class_q == ubxanr_pkg::UBX_CLASS_ACK);

    phase_d       = phase_q;
    frame_class_d = frame_class_q;
    frame_ident_d = frame_ident_q;
    sum_a_d       = sum_a_q;
    sum_b_d       = sum_b_q;
    rx_sum_a_d    = rx_sum_a_q;
    pay_len_d     = pay_len_q;
    pay_idx_d     = pay_idx_q;
    head0_d       = head0_q;
    head1_d       = head1_q;
    elapsed_d     = elapsed_q;
    armed_d       = armed_q;
    fails_d       = fails_q;
    verdict       = ubxanr_pkg::VERDICT_NONE;

    unique case (item_i.mode)
      ubxanr_pkg::MODE_START: begin
        phase_d       = PH_SYNC1;
        frame_class_d = '0;
        frame_ident_d = '0;
        sum_a_d       = '0;
        sum_b_d       = '0;
        rx_sum_a_d    = '0;
        pay_len_d     = '0;
        pay_idx_d     = '0;
        head0_d       = '0;
        head1_d       = '0;
        elapsed_d     = '0;
        armed_d       = 1'b1;
      end
      ubxanr_pkg::MODE_TICK: begin
        if (armed_q) begin
          elapsed_d = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
          if (elapsed_d >= cfg_i.timeout_ms) begin
            verdict = ubxanr_pkg::VERDICT_TIMEOUT;
            fails_d = fails_inc;
            armed_d = 1'b0;
          end
        end
      end
      ubxanr_pkg::MODE_BYTE: begin
        if (armed_q) begin
          unique case (phase_q)
            PH_SYNC2: begin
              if (b == ubxanr_pkg::UBX_SYNC2) begin
                phase_d = PH_CLASS;
              end else if (b != ubxanr_pkg::UBX_SYNC1) begin
                phase_d = PH_SYNC1;
              end
            end
            PH_CLASS: begin
              frame_class_d = b;
              sum_a_d       = b;
              sum_b_d       = b;
              phase_d       = PH_IDENT;
            end
            PH_IDENT: begin
              frame_ident_d = b;
              sum_a_d       = add_a;
              sum_b_d       = add_b;
              phase_d       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              pay_len_d = {8'd0, b};
              sum_a_d   = add_a;
              sum_b_d   = add_b;
              phase_d   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              pay_len_d = len_full;
              sum_a_d   = add_a;
              sum_b_d   = add_b;
              pay_idx_d = '0;
              phase_d   = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              sum_a_d = add_a;
              sum_b_d = add_b;
              if (pay_idx_q == 16'd0) begin
                head0_d = b;
              end else if (pay_idx_q == 16'd1) begin
                head1_d = b;
              end
              pay_idx_d = idx_inc;
              if (idx_inc >= pay_len_q) begin
                phase_d = PH_CK_A;
              end
            end
            PH_CK_A: begin
              rx_sum_a_d = b;
              phase_d    = PH_CK_B;
            end
            PH_CK_B: begin
              if (frame_ok) begin
                if (frame_ident_q == ubxanr_pkg::UBX_ID_ACK) begin
                  verdict = ubxanr_pkg::VERDICT_ACK;
                  armed_d = 1'b0;
                end else if (frame_ident_q == ubxanr_pkg::UBX_ID_NAK) begin
                  verdict = ubxanr_pkg::VERDICT_NAK;
                  fails_d = fails_inc;
                  armed_d = 1'b0;
                end
              end
              phase_d = PH_SYNC1;
            end
            default: begin
              // Waiting for the first sync byte; unused codes land here too.
              phase_d = (b == ubxanr_pkg::UBX_SYNC1) ? PH_SYNC2 : PH_SYNC1;
            end
          endcase
        end
      end
      default: ;
    endcase

    res_o.verdict    = verdict;
    res_o.fail_count = fails_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SYNC1;
      frame_class_q <= '0;
      frame_ident_q <= '0;
      sum_a_q       <= '0;
      sum_b_q       <= '0;
      rx_sum_a_q    <= '0;
      pay_len_q     <= '0;
      pay_idx_q     <= '0;
      head0_q       <= '0;
      head1_q       <= '0;
      elapsed_q     <= '0;
      armed_q       <= 1'b0;
      fails_q       <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      frame_class_q <= frame_class_d;
      frame_ident_q <= frame_ident_d;
      sum_a_q       <= sum_a_d;
      sum_b_q       <= sum_b_d;
      rx_sum_a_q    <= rx_sum_a_d;
      pay_len_q     <= pay_len_d;
      pay_idx_q     <= pay_idx_d;
      head0_q       <= head0_d;
      head1_q       <= head1_d;
      elapsed_q     <= elapsed_d;
      armed_q       <= armed_d;
      fails_q       <= fails_d;
    end
  end

endmodule

[rtl/core/ubx_ack_nak_receiver.sv]
// ----------------------------------------------------------------------------
// ubx_ack_nak_receiver: waits for a UBX ACK or NAK of an expected message.
// Stages: input reg, then result reg, from input transaction to result.
// Throughput: 1 transaction per cycle while the output is not stalled.
// Reset (rst_ni, async low): idle, parser and counters zero, config defaults.
// ----------------------------------------------------------------------------
//
// Each input transaction is either a received byte, a one millisecond tick
// or a start command, and it produces exactly one result transaction that
// carries the verdict (none, ACK, NAK, timeout) and the saturating failure
// count after that transaction.
//
// The datapath has two register stages. An accepted input transaction lands
// in the input register; from there the core updates the parser, checksum,
// timer and failure counter and the result is captured in the
// output register. Both stages move together whenever the output register is
// empty or being drained, so a full pipeline takes one transaction per cycle
// as long as results are taken. While a finished result waits downstream, the
// input register still takes one more transaction and then the input stalls
// until the result is taken.
//
// Configuration writes go straight to the register file. The user must issue
// them only while the block holds no transaction in flight; nothing checks it.
module ubx_ack_nak_receiver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ubxanr_pkg::in_t                  in_data_i,
  // Output channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ubxanr_pkg::out_t                 out_data_o,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [ubxanr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ubxanr_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  ubxanr_pkg::cfg_t cfg;
  ubxanr_pkg::in_t  in_q;
  ubxanr_pkg::out_t out_q;
  ubxanr_pkg::out_t res;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             step;
  logic             in_accept;

  // The pipeline moves when the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  ubxanr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ubxanr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: refilled in the same cycle that its transaction moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Result register: holds its transaction steady while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/sv/ubxanr_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxanr_tb_pkg
// Scoreboard for the UBX acknowledge receiver: it tracks the frame parser,
// the millisecond timer and the failure counter of the block, predicts the
// result of every accepted input transaction and checks the results in order.
// ----------------------------------------------------------------------------
package ubxanr_tb_pkg;
  import ubxanr_pkg::*;

  // The mode code that the block does not use.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    SEEK_SYNC1,
    SEEK_SYNC2,
    TAKE_CLASS,
    TAKE_IDENT,
    TAKE_LEN_LO,
    TAKE_LEN_HI,
    TAKE_PAYLOAD,
    TAKE_CK_A,
    TAKE_CK_B
  } frame_phase_e;

  class verdict_scoreboard;
    logic [7:0]   want_class;
    logic [7:0]   want_ident;
    logic [15:0]  limit_ms;

    frame_phase_e phase;
    logic [7:0]   frame_class;
    logic [7:0]   frame_ident;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [7:0]   sent_sum_a;
    logic [15:0]  body_len;
    logic [15:0]  body_pos;
    logic [7:0]   body_head [2];
    logic [15:0]  elapsed_ms;
    logic         armed;
    logic [15:0]  fail_tally;

    out_t         awaited_results[$];
    int unsigned  mismatch_count;

    function new();
      want_class = EXPECT_CLASS_RST;
      want_ident = EXPECT_ID_RST;
      limit_ms = TIMEOUT_MS_RST;
      restart_frame();
      elapsed_ms = '0;
      armed = 1'b0;
      fail_tally = '0;
      mismatch_count = 0;
    endfunction

    function void restart_frame();
      phase = SEEK_SYNC1;
      frame_class = '0;
      frame_ident = '0;
      sum_a = '0;
      sum_b = '0;
      sent_sum_a = '0;
      body_len = '0;
      body_pos = '0;
      body_head[0] = '0;
      body_head[1] = '0;
    endfunction

    function void add_to_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void count_failure();
      if (fail_tally != 16'hFFFF) fail_tally = fail_tally + 16'd1;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_EXPECT_CLASS: want_class = value[7:0];
        CFG_EXPECT_ID:    want_ident = value[7:0];
        CFG_TIMEOUT_MS:   limit_ms = value;
        default: ;
      endcase
    endfunction

    // Advances the tracked receiver by one input transaction.
    function out_t advance_receiver(in_t item);
      out_t       res;
      logic [7:0] b;
      b = item.data_byte;
      res.verdict = VERDICT_NONE;
      case (item.mode)
        MODE_START: begin
          restart_frame();
          elapsed_ms = '0;
          armed = 1'b1;
        end
        MODE_TICK: begin
          if (armed) begin
            if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
            if (elapsed_ms >= limit_ms) begin
              res.verdict = VERDICT_TIMEOUT;
              count_failure();
              armed = 1'b0;
            end
          end
        end
        MODE_BYTE: begin
          if (armed) begin
            case (phase)
              SEEK_SYNC2: begin
                if (b == UBX_SYNC2) phase = TAKE_CLASS;
                else if (b != UBX_SYNC1) phase = SEEK_SYNC1;
              end
              TAKE_CLASS: begin
                frame_class = b;
                sum_a = '0;
                sum_b = '0;
                add_to_sum(b);
                phase = TAKE_IDENT;
              end
              TAKE_IDENT: begin
                frame_ident = b;
                add_to_sum(b);
                phase = TAKE_LEN_LO;
              end
              TAKE_LEN_LO: begin
                body_len = {8'h00, b};
                add_to_sum(b);
                phase = TAKE_LEN_HI;
              end
              TAKE_LEN_HI: begin
                body_len[15:8] = b;
                add_to_sum(b);
                body_pos = '0;
                phase = (body_len == 16'd0) ? TAKE_CK_A : TAKE_PAYLOAD;
              end
              TAKE_PAYLOAD: begin
                add_to_sum(b);
                if (body_pos < 16'd2) body_head[body_pos[0]] = b;
                body_pos = body_pos + 16'd1;
                if (body_pos >= body_len) phase = TAKE_CK_A;
              end
              TAKE_CK_A: begin
                sent_sum_a = b;
                phase = TAKE_CK_B;
              end
              TAKE_CK_B: begin
                if (sum_a == sent_sum_a && sum_b == b && body_len >= 16'd2 &&
                    body_head[0] == want_class && body_head[1] == want_ident &&
                    frame_class == UBX_CLASS_ACK) begin
                  if (frame_ident == UBX_ID_ACK) begin
                    res.verdict = VERDICT_ACK;
                  end else if (frame_ident == UBX_ID_NAK) begin
                    res.verdict = VERDICT_NAK;
                    count_failure();
                  end
                end
                if (res.verdict != VERDICT_NONE) armed = 1'b0;
                phase = SEEK_SYNC1;
              end
              default: begin
                // Waiting for the first sync byte, and any code that cannot occur.
                phase = (b == UBX_SYNC1) ? SEEK_SYNC2 : SEEK_SYNC1;
              end
            endcase
          end
        end
        default: ;
      endcase
      res.fail_count = fail_tally;
      return res;
    endfunction

    function void note_transaction(in_t item);
      awaited_results.push_back(advance_receiver(item));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected: verdict %0d fail_count %0d",
                 $time, got.verdict, got.fail_count);
        mismatch_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.verdict !== want.verdict) begin
        $display("%0t: verdict mismatch: expected %0d, actual %0d",
                 $time, want.verdict, got.verdict);
        mismatch_count++;
      end
      if (got.fail_count !== want.fail_count) begin
        $display("%0t: fail_count mismatch: expected %0d, actual %0d",
                 $time, want.fail_count, got.fail_count);
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte, tick, start and unused-mode transactions into the UBX
// acknowledge receiver under random idling on both channels and compares
// every result with the scoreboard's prediction, across several register
// settings.
// ----------------------------------------------------------------------------
module testbench;
  import ubxanr_pkg::*;
  import ubxanr_tb_pkg::*;

  // The length of the receiver's hold-off when pressure is requested.
  localparam int unsigned HOLD_CYCLES = 64;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  verdict_scoreboard sb;

  // Stimulus controls. The main process writes them, but for quiet_cycles,
  // which the watchdog keeps; the receiver reads receiver_idles and hold_reqs.
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned hold_reqs = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  // The register values that the stimulus aims its frames at.
  logic [7:0]  cur_class = EXPECT_CLASS_RST;
  logic [7:0]  cur_ident = EXPECT_ID_RST;
  logic [15:0] cur_timeout = TIMEOUT_MS_RST;

  ubx_ack_nak_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Offers one input transaction, after a random number of idle cycles, and
  // holds it until the block takes it. The payload stays put while stalled.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
    in_t item;
    item.mode = mode;
    item.data_byte = data;
    while (sender_idles && $urandom_range(99) < 32) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(item);
    items_sent++;
  endtask

  // Sends a UBX frame with a correct checksum over class through payload.
  // Only the first twelve payload bytes are sent; a longer frame is left
  // unfinished. A spoiled frame has one bit flipped somewhere, and a chopped
  // frame stops early. Ticks are slipped in between bytes now and then.
  task automatic send_ubx_frame(input logic [7:0] cls, input logic [7:0] ident,
                                input logic [15:0] len, input logic [7:0] head0,
                                input logic [7:0] head1, input bit spoil, input bit chop);
    logic [7:0]  octets[$];
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    int unsigned body;
    int unsigned stop;
    int unsigned k;
    ck_a = '0;
    ck_b = '0;
    body = (len > 16'd12) ? 12 : int'(len);
    octets.push_back(UBX_SYNC1);
    octets.push_back(UBX_SYNC2);
    octets.push_back(cls);
    octets.push_back(ident);
    octets.push_back(len[7:0]);
    octets.push_back(len[15:8]);
    for (k = 0; k < body; k++) begin
      octets.push_back((k == 0) ? head0 : (k == 1) ? head1 : 8'($urandom_range(255)));
    end
    for (k = 2; k < octets.size(); k++) begin
      ck_a = ck_a + octets[k];
      ck_b = ck_b + ck_a;
    end
    if (len <= 16'd12) begin
      octets.push_back(ck_a);
      octets.push_back(ck_b);
    end
    if (spoil) begin
      k = $urandom_range(octets.size() - 1);
      octets[k] = octets[k] ^ 8'(1 << $urandom_range(7));
    end
    stop = chop ? $urandom_range(1, octets.size() - 1) : octets.size();
    for (k = 0; k < stop; k++) begin
      if ($urandom_range(99) < 4) send_item(MODE_TICK, 8'($urandom_range(255)));
      send_item(MODE_BYTE, octets[k]);
    end
  endtask

  // One random sequence: mostly a frame, usually after a start, with random
  // content aimed at the current expectation, sometimes a start with a run
  // of ticks, and sometimes plain noise in every mode.
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [7:0]  head0;
    logic [7:0]  head1;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end else if (pick < 22) begin
      send_item(MODE_START, 8'($urandom_range(255)));
      n = (cur_timeout <= 16'd16) ? $urandom_range(int'(cur_timeout) + 2)
                                  : $urandom_range(1, 6);
      for (k = 0; k < n; k++) send_item(MODE_TICK, 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) != 0) send_item(MODE_START, 8'($urandom_range(255)));
      // A doubled first sync byte must still lead into the frame.
      if ($urandom_range(9) == 0) send_item(MODE_BYTE, UBX_SYNC1);
      cls = ($urandom_range(9) < 8) ? UBX_CLASS_ACK : 8'($urandom_range(255));
      case ($urandom_range(4))
        0, 1:    ident = UBX_ID_ACK;
        2, 3:    ident = UBX_ID_NAK;
        default: ident = 8'($urandom_range(255));
      endcase
      case ($urandom_range(9))
        0:       len = 16'd0;
        1:       len = 16'd1;
        2:       len = 16'($urandom_range(65535));
        3:       len = 16'($urandom_range(3, 6));
        default: len = 16'd2;
      endcase
      head0 = ($urandom_range(9) < 8) ? cur_class : 8'($urandom_range(255));
      head1 = ($urandom_range(9) < 8) ? cur_ident : 8'($urandom_range(255));
      send_ubx_frame(cls, ident, len, head0, head1,
                     $urandom_range(9) == 0, $urandom_range(19) == 0);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) send_random_sequence();
  endtask

  // Stops offering input and waits until every expected result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] cls, input logic [7:0] ident,
                                input logic [15:0] limit);
    cur_class = cls;
    cur_ident = ident;
    cur_timeout = limit;
    write_reg(CFG_EXPECT_CLASS, {8'h00, cls});
    write_reg(CFG_EXPECT_ID, {8'h00, ident});
    write_reg(CFG_TIMEOUT_MS, limit);
  endtask

  // Receiver side. It stalls at random, or for a long stretch when the main
  // process asks for pressure, so that the block fills and stalls its input.
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_idles && ($urandom_range(99) < 32);
      end
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the registers at their reset values. While idle,
    // bytes, ticks and the unused mode change nothing.
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_UNUSED, 8'hA5);
    send_item(MODE_START, 8'h5A);
    // A repeated first sync byte, then a zero-length acknowledge frame that
    // goes straight to its checksum and gives no verdict.
    send_item(MODE_BYTE, UBX_SYNC1);
    send_ubx_frame(UBX_CLASS_ACK, UBX_ID_ACK, 16'd0, 8'h00, 8'h00, 1'b0, 1'b0);
    // A start while armed rearms; then a proper acknowledge.
    send_item(MODE_START, 8'h00);
    send_ubx_frame(UBX_CLASS_ACK, UBX_ID_ACK, 16'd2, cur_class, cur_ident, 1'b0, 1'b0);

    run_random(100);

    // Lowest expectation and a one millisecond timeout.
    settle();
    apply_settings(8'h00, 8'h00, 16'd1);
    run_random(100);

    // Highest values; the receiver holds off at the start of this phase.
    settle();
    apply_settings(8'hFF, 8'hFF, 16'hFFFF);
    hold_reqs++;
    run_random(100);

    // A timeout register of zero times out on the first tick.
    settle();
    apply_settings(8'h06, 8'h08, 16'd0);
    run_random(80);

    // A random setting, with no idling on either side.
    settle();
    apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(2, 12)));
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    run_random(120);

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ubxanr_pkg.sv
rtl/core/ubxanr_cfg.sv
rtl/core/ubxanr_core.sv
rtl/core/ubx_ack_nak_receiver.sv
tb/sv/ubxanr_tb_pkg.sv
tb/sv/testbench.sv
